### rtl/pctbl_pkg.sv
// Shared widths, register indexes, reset values and helpers for the
// per-client token bucket limiter. No dependencies.
`timescale 1ns / 1ps

package pctbl_pkg;

    localparam int CLIENTS_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int KEY_W  = 32;
    localparam int TICK_W = 32;
    localparam int CAP_W  = 16;
    localparam int RATE_W = 24;
    localparam int TMO_W  = 32;
    localparam int CNT_W  = 32;
    localparam int SLOT_W = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RST = 16'd1000;
    localparam logic [RATE_W-1:0] REFILL_RST   = 24'd65536;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 32'd300000;

    // Saturating increment used by all packet counters.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/pctbl_refill.sv
// Bucket refill datapath: registered elapsed-times-rate product, then
// saturation at capacity and the one-token take. Depends on pctbl_pkg.
`timescale 1ns / 1ps

module pctbl_refill #(
    parameter int FRAC_BITS = pctbl_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    load,
    input  logic [pctbl_pkg::TICK_W-1:0]            elapsed,
    input  logic [pctbl_pkg::RATE_W-1:0]            rate,
    input  logic [pctbl_pkg::CAP_W+FRAC_BITS-1:0]   tokens,
    input  logic [pctbl_pkg::CAP_W-1:0]             capacity,
    output logic [pctbl_pkg::CAP_W+FRAC_BITS-1:0]   level,
    output logic                                    pass
);

    localparam int TOK_W  = pctbl_pkg::CAP_W + FRAC_BITS;
    localparam int PROD_W = pctbl_pkg::TICK_W + pctbl_pkg::RATE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [TOK_W-1:0] ONE = {{(TOK_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [PROD_W-1:0] prod_reg;
    logic [TOK_W-1:0]  tok_reg;
    logic [TOK_W-1:0]  full_reg;

    logic [SUM_W-1:0]  sum;
    logic [TOK_W-1:0]  sat;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= elapsed * rate;
            tok_reg  <= tokens;
            full_reg <= {capacity, {FRAC_BITS{1'b0}}};
        end
    end

    always_comb begin
        sum   = SUM_W'(prod_reg) + SUM_W'(tok_reg);
        sat   = (sum > SUM_W'(full_reg)) ? full_reg : sum[TOK_W-1:0];
        pass  = (sat >= ONE);
        level = pass ? sat - ONE : sat;
    end

endmodule

### rtl/per_client_token_bucket_limiter.sv
// Per-client token bucket limiter top level: client table memory, scan
// sequencer, configuration registers and stream ports. Depends on pctbl_pkg
// and pctbl_refill.
`timescale 1ns / 1ps

// One request is one packet arrival; one result comes back for each. The
// client table lives in a single-port-read memory with a registered read,
// and every request walks it one entry per cycle: a request whose client is
// new or not found walks the whole table, and one whose live entry sits at
// index k stops there. The next request is taken while a finished result
// still waits on the master side. After reset the table is cleared one entry
// per cycle, so no request is taken until the clear is done; configuration
// writes are taken at any time.
module per_client_token_bucket_limiter #(
    parameter int CLIENTS   = pctbl_pkg::CLIENTS_DEF,
    parameter int FRAC_BITS = pctbl_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [pctbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pctbl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // client_ip [31:0], now_ticks [63:32]
    input  logic [pctbl_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accepted [0], slot [6:1], new_entry [7], client_passed [39:8],
    // client_dropped [71:40], total_dropped [103:72]
    output logic [pctbl_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int TOK_W = pctbl_pkg::CAP_W + FRAC_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

    typedef struct packed {
        logic                          valid;
        logic [pctbl_pkg::KEY_W-1:0]   key;
        logic [pctbl_pkg::TICK_W-1:0]  seen;
        logic [pctbl_pkg::TICK_W-1:0]  refill;
        logic [TOK_W-1:0]              tokens;
        logic [pctbl_pkg::CNT_W-1:0]   passed;
        logic [pctbl_pkg::CNT_W-1:0]   dropped;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_UPD
    } state_t;

    // Configuration.
    logic [pctbl_pkg::CAP_W-1:0]  capacity_reg;
    logic [pctbl_pkg::RATE_W-1:0] rate_reg;
    logic [pctbl_pkg::TMO_W-1:0]  timeout_reg;

    // Control and request state.
    state_t                       state_reg;
    logic [IDX_W-1:0]             clr_reg;
    logic [pctbl_pkg::KEY_W-1:0]  ip_reg;
    logic [pctbl_pkg::TICK_W-1:0] now_reg;
    logic [IDX_W-1:0]             iss_reg;
    logic                         iss_done_reg;
    logic                         dv_reg;
    logic [IDX_W-1:0]             di_reg;
    logic                         empty_found_reg;
    logic [IDX_W-1:0]             empty_idx_reg;
    logic [IDX_W-1:0]             oldest_idx_reg;
    logic [pctbl_pkg::TICK_W-1:0] oldest_age_reg;
    logic [IDX_W-1:0]             slot_reg;
    logic                         created_reg;
    entry_t                       rec_reg;
    logic [pctbl_pkg::CNT_W-1:0]  global_reg;
    logic                         m_tvalid_reg;
    logic [pctbl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Table memory.
    entry_t                       entry_mem [CLIENTS];
    entry_t                       rd_data_reg;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_wa;
    entry_t                       mem_wd;

    // Scan helpers.
    logic                         empty_found_next;
    logic [IDX_W-1:0]             empty_idx_next;
    logic [IDX_W-1:0]             oldest_idx_next;
    logic [pctbl_pkg::TICK_W-1:0] oldest_age_next;
    logic [pctbl_pkg::TICK_W-1:0] age;
    logic                         timed_out;
    logic                         hit;
    logic                         last_exam;

    // Update helpers.
    logic                         out_free;
    logic                         refill_load;
    logic [TOK_W-1:0]             level;
    logic                         pass;
    entry_t                       upd;
    logic [pctbl_pkg::CNT_W-1:0]  total_next;
    logic [31:0]                  slot_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign refill_load = (state_reg == ST_MUL);

    pctbl_refill #(
        .FRAC_BITS(FRAC_BITS)
    ) u_refill (
        .aclk     (aclk),
        .load     (refill_load),
        .elapsed  (now_reg - rec_reg.refill),
        .rate     (rate_reg),
        .tokens   (rec_reg.tokens),
        .capacity (capacity_reg),
        .level    (level),
        .pass     (pass)
    );

    // Examine the entry read in the previous cycle.
    always_comb begin
        age       = now_reg - rd_data_reg.seen;
        timed_out = age > timeout_reg;
        hit       = dv_reg && rd_data_reg.valid && !timed_out && (rd_data_reg.key == ip_reg);
        last_exam = dv_reg && (di_reg == LAST_IDX);

        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_age_next  = oldest_age_reg;
        if (dv_reg) begin
            if (!rd_data_reg.valid) begin
                if (!empty_found_reg) begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = di_reg;
                end
            end else if (timed_out && (age > oldest_age_reg)) begin
                oldest_idx_next = di_reg;
                oldest_age_next = age;
            end
        end
    end

    // Write-back record, result fields and the table write (clear or update).
    always_comb begin
        upd        = rec_reg;
        upd.refill = now_reg;
        upd.tokens = level;
        total_next = global_reg;
        if (pass) begin
            upd.seen   = now_reg;
            upd.passed = pctbl_pkg::sat_inc(rec_reg.passed);
        end else begin
            upd.dropped = pctbl_pkg::sat_inc(rec_reg.dropped);
            total_next  = pctbl_pkg::sat_inc(global_reg);
        end
        slot_wide = 32'(slot_reg);

        mem_we = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && out_free);
        mem_wa = (state_reg == ST_CLEAR) ? clr_reg : slot_reg;
        mem_wd = (state_reg == ST_CLEAR) ? '0 : upd;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[iss_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= pctbl_pkg::CAPACITY_RST;
            rate_reg     <= pctbl_pkg::REFILL_RST;
            timeout_reg  <= pctbl_pkg::TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pctbl_pkg::CFG_CAPACITY: capacity_reg <= cfg_data[pctbl_pkg::CAP_W-1:0];
                pctbl_pkg::CFG_REFILL:   rate_reg     <= cfg_data[pctbl_pkg::RATE_W-1:0];
                pctbl_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[pctbl_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            iss_reg      <= '0;
            iss_done_reg <= 1'b1;
            dv_reg       <= 1'b0;
            global_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A result taken while the next one is loaded is replaced below.
            if (m_tvalid_reg && m_tready && (state_reg != ST_UPD)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == LAST_IDX) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ip_reg          <= s_tdata[31:0];
                        now_reg         <= s_tdata[63:32];
                        iss_reg         <= '0;
                        iss_done_reg    <= 1'b0;
                        dv_reg          <= 1'b0;
                        empty_found_reg <= 1'b0;
                        empty_idx_reg   <= '0;
                        oldest_idx_reg  <= '0;
                        oldest_age_reg  <= '0;
                        state_reg       <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    empty_found_reg <= empty_found_next;
                    empty_idx_reg   <= empty_idx_next;
                    oldest_idx_reg  <= oldest_idx_next;
                    oldest_age_reg  <= oldest_age_next;
                    if (hit) begin
                        slot_reg     <= di_reg;
                        rec_reg      <= rd_data_reg;
                        created_reg  <= 1'b0;
                        iss_done_reg <= 1'b1;
                        dv_reg       <= 1'b0;
                        state_reg    <= ST_MUL;
                    end else if (last_exam) begin
                        slot_reg       <= empty_found_next ? empty_idx_next : oldest_idx_next;
                        rec_reg.valid  <= 1'b1;
                        rec_reg.key    <= ip_reg;
                        rec_reg.seen   <= now_reg;
                        rec_reg.refill <= now_reg;
                        rec_reg.tokens <= {capacity_reg, {FRAC_BITS{1'b0}}};
                        rec_reg.passed <= '0;
                        rec_reg.dropped <= '0;
                        created_reg    <= 1'b1;
                        dv_reg         <= 1'b0;
                        state_reg      <= ST_MUL;
                    end else if (!iss_done_reg) begin
                        // Issue one read per cycle; the data is examined in the next cycle.
                        iss_reg <= iss_reg + IDX_W'(1);
                        di_reg  <= iss_reg;
                        dv_reg  <= 1'b1;
                        if (iss_reg == LAST_IDX) begin
                            iss_done_reg <= 1'b1;
                        end
                    end else begin
                        dv_reg <= 1'b0;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (out_free) begin
                        global_reg   <= total_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {total_next, upd.dropped, upd.passed, created_reg,
                                         slot_wide[pctbl_pkg::SLOT_W-1:0], pass};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/pctbl_checker.sv
// Checker for the per-client token bucket limiter: keeps its own client table,
// predicts one result per accepted request and compares the result stream.
// Depends on pctbl_pkg.
`timescale 1ns / 1ps

module pctbl_checker
    import pctbl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    output int                     failures,
    output int                     outstanding
);

    localparam int TABLE_SIZE = CLIENTS_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int REPORT_MAX = 10;

    // Same layout as m_tdata: accepted sits in the lowest bit.
    typedef struct packed {
        logic [CNT_W-1:0]  total_dropped;
        logic [CNT_W-1:0]  client_dropped;
        logic [CNT_W-1:0]  client_passed;
        logic              new_entry;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
    } verdict_t;

    logic [CAP_W-1:0]  capacity;
    logic [RATE_W-1:0] refill_rate;
    logic [TMO_W-1:0]  timeout;

    logic              in_use    [TABLE_SIZE];
    logic [KEY_W-1:0]  owner     [TABLE_SIZE];
    logic [TICK_W-1:0] seen_at   [TABLE_SIZE];
    logic [TICK_W-1:0] filled_at [TABLE_SIZE];
    logic [63:0]       tokens    [TABLE_SIZE];
    logic [CNT_W-1:0]  passed    [TABLE_SIZE];
    logic [CNT_W-1:0]  dropped   [TABLE_SIZE];
    logic [CNT_W-1:0]  drops_total;

    verdict_t pending_verdicts [$];
    int       results_seen;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // Runs one packet through the predicted table and returns its verdict.
    function automatic verdict_t police_packet(input logic [KEY_W-1:0] ip,
                                               input logic [TICK_W-1:0] now);
        logic [63:0]       full;
        logic [63:0]       one;
        logic [63:0]       lvl;
        logic [TICK_W-1:0] age;
        logic [TICK_W-1:0] oldest_age;
        logic [TICK_W-1:0] elapsed;
        int                hit;
        int                vacant;
        int                oldest;
        int                s;
        int                i;
        bit                fresh;
        bit                pass;
        verdict_t          v;
        full = 64'(capacity) << FRAC;
        one = 64'd1 << FRAC;
        hit = -1;
        vacant = -1;
        oldest = 0;
        oldest_age = '0;
        fresh = 1'b0;
        for (i = 0; i < TABLE_SIZE; i++) begin
            if (hit < 0) begin
                if (!in_use[i]) begin
                    if (vacant < 0) vacant = i;
                end else begin
                    age = now - seen_at[i];
                    // A timed-out entry is only a replacement candidate, never a match.
                    if (age > timeout) begin
                        if (age > oldest_age) begin
                            oldest_age = age;
                            oldest = i;
                        end
                    end else if (owner[i] == ip) begin
                        hit = i;
                    end
                end
            end
        end
        if (hit >= 0) begin
            s = hit;
        end else begin
            s = (vacant >= 0) ? vacant : oldest;
            fresh = 1'b1;
            in_use[s] = 1'b1;
            owner[s] = ip;
            seen_at[s] = now;
            filled_at[s] = now;
            tokens[s] = full;
            passed[s] = '0;
            dropped[s] = '0;
        end
        elapsed = now - filled_at[s];
        lvl = tokens[s] + 64'(elapsed) * 64'(refill_rate);
        if (lvl > full) lvl = full;
        filled_at[s] = now;
        pass = (lvl >= one);
        if (pass) begin
            lvl = lvl - one;
            seen_at[s] = now;
            passed[s] = count_up(passed[s]);
        end else begin
            dropped[s] = count_up(dropped[s]);
            drops_total = count_up(drops_total);
        end
        tokens[s] = lvl;
        v.accepted = pass;
        v.slot = SLOT_W'(s);
        v.new_entry = fresh;
        v.client_passed = passed[s];
        v.client_dropped = dropped[s];
        v.total_dropped = drops_total;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        int       i;
        if (!aresetn) begin
            capacity = CAPACITY_RST;
            refill_rate = REFILL_RST;
            timeout = TIMEOUT_RST;
            for (i = 0; i < TABLE_SIZE; i++) in_use[i] = 1'b0;
            drops_total = '0;
            pending_verdicts.delete();
            results_seen = 0;
            failures = 0;
            outstanding = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CAPACITY: capacity = cfg_data[CAP_W-1:0];
                    CFG_REFILL:   refill_rate = cfg_data[RATE_W-1:0];
                    CFG_TIMEOUT:  timeout = cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            // A result can never belong to a request taken at the same edge,
            // so results are matched before new requests are queued.
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_verdicts.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("result %0d arrived with no request pending: %h",
                                 results_seen, m_tdata);
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("new_entry", 32'(want.new_entry), 32'(got.new_entry));
                    check_field("client_passed", want.client_passed, got.client_passed);
                    check_field("client_dropped", want.client_dropped, got.client_dropped);
                    check_field("total_dropped", want.total_dropped, got.total_dropped);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                pending_verdicts.push_back(police_packet(s_tdata[KEY_W-1:0],
                                                         s_tdata[KEY_W +: TICK_W]));
            outstanding = pending_verdicts.size();
        end
    end

endmodule

### dv/tb_top.sv
// Testbench top for the per-client token bucket limiter: clock, reset, request
// and configuration stimulus, and the verdict. Depends on pctbl_pkg, the block
// and pctbl_checker.
`timescale 1ns / 1ps

module tb_top;
    import pctbl_pkg::*;

    localparam int STALL_PCT      = 24;
    localparam int MAX_GAP        = 90;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 136;
    localparam int POOL_MAX       = 256;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                failures;
    int                outstanding;
    int                quiet_cycles = 0;
    bit                stall_free = 1'b0;
    logic [TICK_W-1:0] tick_now;
    logic [KEY_W-1:0]  client_pool [POOL_MAX];

    per_client_token_bucket_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pctbl_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= stall_free || ($urandom_range(99) >= STALL_PCT);
    end

    // Ends a hung run: no request, result or register write for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Handshakes are sampled at the falling edge, where everything has settled.
    task automatic send_packet(input logic [KEY_W-1:0] ip, input logic [TICK_W-1:0] now);
        int gap;
        bit taken;
        if (!stall_free && $urandom_range(99) < STALL_PCT) begin
            gap = $urandom_range(MAX_GAP, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, ip};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Leaves cfg_we high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_requests();
        write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input logic [RATE_W-1:0] rate,
                             input logic [TMO_W-1:0] tmo, input int pool_n);
        int                k;
        int                pick;
        logic [TICK_W-1:0] span;
        logic [KEY_W-1:0]  ip;
        drain_requests();
        write_reg(CFG_CAPACITY, 32'(cap));
        write_reg(CFG_REFILL, 32'(rate));
        write_reg(CFG_TIMEOUT, tmo);
        cfg_we <= 1'b0;
        for (k = 0; k < pool_n; k++) client_pool[k] = $urandom();
        span = (tmo < 100000) ? tmo + tmo / 2 + 2 : 100000;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            // Mostly repeat visits from the phase's clients, with some strangers.
            if ($urandom_range(99) < 8) begin
                ip = $urandom();
            end else begin
                ip = client_pool[$urandom_range(pool_n - 1)];
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                tick_now = tick_now + $urandom_range(3);
            end else if (pick < 85) begin
                tick_now = tick_now + $urandom_range(span);
            end else if (pick < 97) begin
                tick_now = tick_now + $urandom();
            end else begin
                tick_now = tick_now - $urandom_range(span);
            end
            send_packet(ip, tick_now);
        end
    endtask

    initial begin
        int                 ph;
        logic [CAP_W-1:0]   cap;
        logic [RATE_W-1:0]  rate;
        logic [TMO_W-1:0]   tmo;
        int                 pool_n;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_CAPACITY;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults after reset: extreme keys and times, a match, and a jump to
        // the last tick that times the first entries out.
        send_packet(32'h0000_0000, 32'h0000_0000);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000);
        send_packet(32'h0000_0000, 32'h0000_0001);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // An empty bucket drops every packet of its entry.
        set_reg(CFG_CAPACITY, 32'd0);
        send_packet(32'h1234_5678, 32'hFFFF_FFFF);
        send_packet(32'h1234_5678, 32'hFFFF_FFFF);

        // One token and no refill: pass, then drop; then the fastest refill.
        set_reg(CFG_CAPACITY, 32'd1);
        set_reg(CFG_REFILL, 32'd0);
        send_packet(32'hA5A5_5A5A, 32'h0000_1000);
        send_packet(32'hA5A5_5A5A, 32'h0000_1000);
        set_reg(CFG_REFILL, 32'h00FF_FFFF);
        send_packet(32'hA5A5_5A5A, 32'h0000_1001);

        // With no timeout any nonzero age misses, even for the same key.
        set_reg(CFG_TIMEOUT, 32'd0);
        send_packet(32'hA5A5_5A5A, 32'h0000_1002);
        send_packet(32'h5A5A_A5A5, 32'h0000_1002);
        send_packet(32'h5A5A_A5A5, 32'h0000_1002);

        // The longest timeout never expires, however far time moves.
        set_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_packet(32'h5A5A_A5A5, 32'h8000_1002);
        set_reg(CFG_CAPACITY, 32'd65535);
        send_packet(32'h8000_0001, 32'h8000_1003);

        tick_now = 32'hFFFF_F000;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    cap = 16'hFFFF; rate = 24'hFF_FFFF; tmo = 32'hFFFF_FFFF; pool_n = 40;
                end
                1: begin
                    cap = 16'd1; rate = 24'd0; tmo = 32'd1; pool_n = 20;
                end
                2: begin
                    cap = 16'd2; rate = 24'd1; tmo = 32'd50; pool_n = 100;
                end
                3: begin
                    cap = 16'd4; rate = 24'd32768; tmo = 32'hFFFF_FFFF; pool_n = 90;
                end
                default: begin
                    case ($urandom_range(2))
                        0: cap = 16'd1;
                        1: cap = 16'($urandom_range(8, 1));
                        default: cap = 16'($urandom_range(65535, 1));
                    endcase
                    case ($urandom_range(2))
                        0: rate = 24'd0;
                        1: rate = 24'($urandom_range(131072));
                        default: rate = 24'($urandom());
                    endcase
                    case ($urandom_range(3))
                        0: tmo = $urandom_range(20, 1);
                        1: tmo = $urandom_range(400, 1);
                        2: tmo = TIMEOUT_RST;
                        default: tmo = 32'hFFFF_FFFF;
                    endcase
                    case ($urandom_range(2))
                        0: pool_n = $urandom_range(8, 1);
                        1: pool_n = $urandom_range(70, 1);
                        default: pool_n = $urandom_range(200, 60);
                    endcase
                end
            endcase
            // Two phases run with neither side ever idling.
            stall_free = (ph == 4) || (ph == 5);
            run_phase(cap, rate, tmo, pool_n);
        end
        stall_free = 1'b0;

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
